@@ rtl/mgbc_pkg.sv @@
// ----------------------------------------------------------------------------
// mgbc_pkg
// Shared types, constants and the CRC helper function of the boot sector checker.
// ----------------------------------------------------------------------------
package mgbc_pkg;

    // Action codes carried by each input beat
    localparam logic [1:0] ACT_LBA0   = 2'd0;
    localparam logic [1:0] ACT_LBA1   = 2'd1;
    localparam logic [1:0] ACT_ARRAY  = 2'd2;
    localparam logic [1:0] ACT_FINISH = 2'd3;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    localparam logic [12:0] MIN_SECTOR       = 13'd512;
    localparam logic [12:0] MAX_SECTOR_BYTES = 13'd4096;
    localparam logic [31:0] MAX_ENTRIES      = 32'd128;
    localparam logic [31:0] MIN_ENTRY        = 32'd128;
    localparam logic [31:0] MAX_ENTRY_BYTES  = 32'd512;
    localparam logic [31:0] MIN_HEADER       = 32'd92;

    localparam logic [16:0] MBR_TABLE_START = 17'd446;
    localparam logic [16:0] MBR_SIG_LO      = 17'd510;
    localparam logic [16:0] MBR_SIG_HI      = 17'd511;
    localparam logic [7:0]  BOOT_ACTIVE     = 8'h80;
    localparam logic [7:0]  TYPE_PROTECTIVE = 8'hEE;
    localparam logic [7:0]  SIG_BYTE_LO     = 8'h55;
    localparam logic [7:0]  SIG_BYTE_HI     = 8'hAA;

    localparam logic [7:0] EFI_SIG [8] = '{8'h45, 8'h46, 8'h49, 8'h20,
                                           8'h50, 8'h41, 8'h52, 8'h54};

    // Type GUIDs: ESP, boot, UFS, ZFS, unused (all zero)
    localparam logic [7:0] PART_TYPE_ID [5][16] = '{
        '{8'h28,8'h73,8'h2A,8'hC1,8'h1F,8'hF8,8'hD2,8'h11,
          8'hBA,8'h4B,8'h00,8'hA0,8'hC9,8'h3E,8'hC9,8'h3B},
        '{8'h9D,8'h6B,8'hBD,8'h83,8'h41,8'h7F,8'hDC,8'h11,
          8'hBE,8'h0B,8'h00,8'h15,8'h60,8'hB8,8'h4F,8'h0F},
        '{8'hB6,8'h7C,8'h6E,8'h51,8'hCF,8'h6E,8'hD6,8'h11,
          8'h8F,8'hF8,8'h00,8'h02,8'h2D,8'h09,8'h71,8'h2B},
        '{8'hBA,8'h7C,8'h6E,8'h51,8'hCF,8'h6E,8'hD6,8'h11,
          8'h8F,8'hF8,8'h00,8'h02,8'h2D,8'h09,8'h71,8'h2B},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
    };

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic        result_kind;
        logic        array_wanted;
        logic [63:0] array_lba;
        logic [16:0] array_length;
        logic [2:0]  mbr_flags;
        logic [2:0]  gpt_flags;
        logic [3:0]  type_flags;
        logic        hybrid;
        logic        bios_boot_ok;
        logic        uefi_boot_ok;
    } result_t;

    // Reflected CRC32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/mgbc_if.sv @@
// ----------------------------------------------------------------------------
// mgbc channel interfaces
// Valid/ready channels for input items, results and the configuration write.
// ----------------------------------------------------------------------------
interface mgbc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface mgbc_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        array_wanted;
    logic [63:0] array_lba;
    logic [16:0] array_length;
    logic [2:0]  mbr_flags;
    logic [2:0]  gpt_flags;
    logic [3:0]  type_flags;
    logic        hybrid;
    logic        bios_boot_ok;
    logic        uefi_boot_ok;
    modport source (output valid, output result_kind, output array_wanted,
                    output array_lba, output array_length, output mbr_flags,
                    output gpt_flags, output type_flags, output hybrid,
                    output bios_boot_ok, output uefi_boot_ok, input ready);
    modport sink (input valid, input result_kind, input array_wanted,
                  input array_lba, input array_length, input mbr_flags,
                  input gpt_flags, input type_flags, input hybrid,
                  input bios_boot_ok, input uefi_boot_ok, output ready);
endinterface

interface mgbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] sector_bytes;
    modport source (output valid, output sector_bytes, input ready);
    modport sink (input valid, input sector_bytes, output ready);
endinterface

@@ rtl/mgbc_core.sv @@
// ----------------------------------------------------------------------------
// mgbc_core
// Per-byte disk state update and the registered result slot.
// ----------------------------------------------------------------------------
module mgbc_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             stage_valid,
    input  mgbc_pkg::item_t  stage_item,
    input  logic [12:0]      sector_bytes,
    output logic             advance,
    output logic             res_valid,
    input  logic             res_ready,
    output mgbc_pkg::result_t res_data
);
    import mgbc_pkg::*;

    logic [1:0]  last_phase_reg, last_phase_next;
    logic [16:0] byte_offset_reg, byte_offset_next;
    logic [31:0] crc_accum_reg, crc_accum_next;
    logic [31:0] header_length_reg, header_length_next;
    logic [31:0] header_crc_stored_reg, header_crc_stored_next;
    logic [31:0] entry_total_reg, entry_total_next;
    logic [31:0] entry_bytes_reg, entry_bytes_next;
    logic [63:0] table_lba_reg, table_lba_next;
    logic [31:0] table_crc_stored_reg, table_crc_stored_next;
    logic [8:0]  entry_offset_reg, entry_offset_next;
    logic [4:0]  guid_candidates_reg, guid_candidates_next;
    logic        signature_candidate_reg, signature_candidate_next;
    logic [2:0]  mbr_seen_reg, mbr_seen_next;
    logic [2:0]  gpt_seen_reg, gpt_seen_next;
    logic [3:0]  types_seen_reg, types_seen_next;
    logic        table_ready_reg, table_ready_next;
    logic [16:0] table_len_reg, table_len_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;
    logic        res_load;
    logic [12:0] sec;
    logic        fire;

    // Clamp the sector size into the supported range
    assign sec = (sector_bytes < MIN_SECTOR) ? MIN_SECTOR :
                 (sector_bytes > MAX_SECTOR_BYTES) ? MAX_SECTOR_BYTES : sector_bytes;

    assign advance   = !res_valid_reg || res_ready;
    assign fire      = stage_valid && advance;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Next state for one byte or finish
    always_comb
    begin
        logic [1:0]  act;
        logic [7:0]  b;
        logic [31:0] off32;
        logic [3:0]  pos;
        logic        hl_ok;
        logic        complete;
        logic [2:0]  mf;
        logic [2:0]  gf;
        logic [3:0]  tf;
        logic        found;
        logic        hdr_good;
        logic [31:0] eo_inc;
        act   = stage_item.action;
        b     = stage_item.data_byte;
        off32 = 32'd0;
        pos   = 4'd0;
        hl_ok = 1'b0;
        complete = 1'b0;
        mf = 3'd0;
        gf = 3'd0;
        tf = 4'd0;
        found = 1'b0;
        hdr_good = 1'b0;
        eo_inc = 32'd0;
        last_phase_next          = last_phase_reg;
        byte_offset_next         = byte_offset_reg;
        crc_accum_next           = crc_accum_reg;
        header_length_next       = header_length_reg;
        header_crc_stored_next   = header_crc_stored_reg;
        entry_total_next         = entry_total_reg;
        entry_bytes_next         = entry_bytes_reg;
        table_lba_next           = table_lba_reg;
        table_crc_stored_next    = table_crc_stored_reg;
        entry_offset_next        = entry_offset_reg;
        guid_candidates_next     = guid_candidates_reg;
        signature_candidate_next = signature_candidate_reg;
        mbr_seen_next            = mbr_seen_reg;
        gpt_seen_next            = gpt_seen_reg;
        types_seen_next          = types_seen_reg;
        table_ready_next         = table_ready_reg;
        table_len_next           = table_len_reg;
        res_load = 1'b0;
        res_next = '0;

        if (act == ACT_FINISH)
        begin
            // Build the report, then start a new disk
            complete = (last_phase_reg == ACT_ARRAY) && (table_len_reg != 17'd0) &&
                       (byte_offset_reg == table_len_reg);
            mf = mbr_seen_reg[0] ? mbr_seen_reg : 3'd0;
            found = gpt_seen_reg[0];
            gf = {complete & gpt_seen_reg[2], found & gpt_seen_reg[1], found};
            tf = complete ? types_seen_reg : 4'd0;
            hdr_good = gf[0] && gf[1];
            res_load = 1'b1;
            res_next.result_kind   = 1'b1;
            res_next.mbr_flags     = mf;
            res_next.gpt_flags     = gf;
            res_next.type_flags    = tf;
            res_next.hybrid        = mf[2] && complete;
            res_next.bios_boot_ok  = (mf[0] && mf[1] && !mf[2]) || (hdr_good && tf[1]);
            res_next.uefi_boot_ok  = hdr_good && tf[0];
            last_phase_next = ACT_LBA0;
            mbr_seen_next   = 3'd0;
            byte_offset_next = 17'd0;
            crc_accum_next = CRC_ONES;
            header_length_next = 32'd0;
            header_crc_stored_next = 32'd0;
            entry_total_next = 32'd0;
            entry_bytes_next = 32'd0;
            table_lba_next = 64'd0;
            table_crc_stored_next = 32'd0;
            entry_offset_next = 9'd0;
            guid_candidates_next = 5'h1F;
            signature_candidate_next = 1'b1;
            gpt_seen_next = 3'd0;
            types_seen_next = 4'd0;
            table_ready_next = 1'b0;
            table_len_next = 17'd0;
        end
        else
        begin
            // Phase change clears state
            if (act != last_phase_reg)
            begin
                byte_offset_next = 17'd0;
                crc_accum_next = CRC_ONES;
                entry_offset_next = 9'd0;
                guid_candidates_next = 5'h1F;
                types_seen_next = 4'd0;
                if (act == ACT_ARRAY)
                begin
                    gpt_seen_next[2] = 1'b0;
                end
                else
                begin
                    header_length_next = 32'd0;
                    header_crc_stored_next = 32'd0;
                    entry_total_next = 32'd0;
                    entry_bytes_next = 32'd0;
                    table_lba_next = 64'd0;
                    table_crc_stored_next = 32'd0;
                    signature_candidate_next = 1'b1;
                    gpt_seen_next = 3'd0;
                    table_ready_next = 1'b0;
                    table_len_next = 17'd0;
                    if (act == ACT_LBA0)
                    begin
                        mbr_seen_next = 3'd0;
                    end
                end
                last_phase_next = act;
            end

            off32 = {15'd0, byte_offset_next};

            if (act == ACT_LBA0)
            begin
                // MBR entries and boot signature
                if (byte_offset_next < {4'd0, sec})
                begin
                    if (byte_offset_next >= MBR_TABLE_START && byte_offset_next < MBR_SIG_LO)
                    begin
                        pos = 4'(byte_offset_next - MBR_TABLE_START);
                        if (pos == 4'd0 && b == BOOT_ACTIVE)
                        begin
                            mbr_seen_next[1] = 1'b1;
                        end
                        if (pos == 4'd4 && b == TYPE_PROTECTIVE)
                        begin
                            mbr_seen_next[2] = 1'b1;
                        end
                    end
                    else if (byte_offset_next == MBR_SIG_LO)
                    begin
                        signature_candidate_next = (b == SIG_BYTE_LO);
                    end
                    else if (byte_offset_next == MBR_SIG_HI)
                    begin
                        if (signature_candidate_next && b == SIG_BYTE_HI)
                        begin
                            mbr_seen_next[0] = 1'b1;
                        end
                    end
                    byte_offset_next = byte_offset_next + 17'd1;
                end
            end
            else if (act == ACT_LBA1)
            begin
                // GPT header fields and header CRC
                if (byte_offset_next < {4'd0, sec})
                begin
                    if (off32 < 32'd8)
                    begin
                        if (b != EFI_SIG[off32[2:0]])
                        begin
                            signature_candidate_next = 1'b0;
                        end
                        if (off32 == 32'd7 && signature_candidate_next)
                        begin
                            gpt_seen_next[0] = 1'b1;
                        end
                    end
                    else if (off32 >= 32'd12 && off32 < 32'd16)
                    begin
                        header_length_next[8*off32[1:0] +: 8] =
                            header_length_next[8*off32[1:0] +: 8] | b;
                    end
                    else if (off32 >= 32'd16 && off32 < 32'd20)
                    begin
                        header_crc_stored_next[8*off32[1:0] +: 8] =
                            header_crc_stored_next[8*off32[1:0] +: 8] | b;
                    end
                    else if (off32 >= 32'd72 && off32 < 32'd80)
                    begin
                        table_lba_next[8*off32[2:0] +: 8] =
                            table_lba_next[8*off32[2:0] +: 8] | b;
                    end
                    else if (off32 >= 32'd80 && off32 < 32'd84)
                    begin
                        entry_total_next[8*off32[1:0] +: 8] =
                            entry_total_next[8*off32[1:0] +: 8] | b;
                    end
                    else if (off32 >= 32'd84 && off32 < 32'd88)
                    begin
                        entry_bytes_next[8*off32[1:0] +: 8] =
                            entry_bytes_next[8*off32[1:0] +: 8] | b;
                    end
                    else if (off32 >= 32'd88 && off32 < 32'd92)
                    begin
                        table_crc_stored_next[8*off32[1:0] +: 8] =
                            table_crc_stored_next[8*off32[1:0] +: 8] | b;
                    end
                    if (off32 < 32'd16 || off32 < header_length_next)
                    begin
                        crc_accum_next = crc_byte(crc_accum_next,
                            (off32 >= 32'd16 && off32 < 32'd20) ? 8'd0 : b);
                    end
                    hl_ok = gpt_seen_next[0] && (header_length_next >= MIN_HEADER) &&
                            (header_length_next <= {19'd0, sec});
                    if (hl_ok && off32 == header_length_next - 32'd1 &&
                        (crc_accum_next ^ CRC_ONES) == header_crc_stored_next)
                    begin
                        gpt_seen_next[1] = 1'b1;
                    end
                    // Last LBA 1 byte: issue the array request
                    if (off32 == {19'd0, sec} - 32'd1)
                    begin
                        table_ready_next = hl_ok && (entry_total_next != 32'd0) &&
                            (entry_total_next <= MAX_ENTRIES) &&
                            (entry_bytes_next >= MIN_ENTRY) &&
                            (entry_bytes_next <= MAX_ENTRY_BYTES) &&
                            (table_lba_next >= 64'd2);
                        table_len_next = table_ready_next ?
                            17'(17'(entry_total_next[7:0]) * 17'(entry_bytes_next[9:0])) :
                            17'd0;
                        res_load = 1'b1;
                        res_next.array_wanted = table_ready_next;
                        res_next.array_lba    = table_ready_next ? table_lba_next : 64'd0;
                        res_next.array_length = table_len_next;
                    end
                    byte_offset_next = byte_offset_next + 17'd1;
                end
            end
            else
            begin
                // Entry array: CRC and type GUID match
                if (byte_offset_next < table_len_next)
                begin
                    crc_accum_next = crc_byte(crc_accum_next, b);
                    if (entry_offset_next == 9'd0)
                    begin
                        guid_candidates_next = 5'h1F;
                    end
                    if (entry_offset_next < 9'd16)
                    begin
                        for (int k = 0; k < 5; k++)
                        begin
                            if (b != PART_TYPE_ID[k][entry_offset_next[3:0]])
                            begin
                                guid_candidates_next[k] = 1'b0;
                            end
                        end
                        if (entry_offset_next == 9'd15 && !guid_candidates_next[4])
                        begin
                            if (guid_candidates_next[0])
                                types_seen_next[0] = 1'b1;
                            else if (guid_candidates_next[1])
                                types_seen_next[1] = 1'b1;
                            else if (guid_candidates_next[2])
                                types_seen_next[2] = 1'b1;
                            else if (guid_candidates_next[3])
                                types_seen_next[3] = 1'b1;
                        end
                    end
                    eo_inc = {23'd0, entry_offset_next} + 32'd1;
                    entry_offset_next = (eo_inc >= entry_bytes_next) ? 9'd0 : eo_inc[8:0];
                    if (byte_offset_next == table_len_next - 17'd1 &&
                        (crc_accum_next ^ CRC_ONES) == table_crc_stored_next)
                    begin
                        gpt_seen_next[2] = 1'b1;
                    end
                    byte_offset_next = byte_offset_next + 17'd1;
                end
            end
        end
    end

    // Result slot: load on a producing beat, drop when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire && res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Hold state between beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg          <= ACT_LBA0;
            byte_offset_reg         <= 17'd0;
            crc_accum_reg           <= CRC_ONES;
            header_length_reg       <= 32'd0;
            header_crc_stored_reg   <= 32'd0;
            entry_total_reg         <= 32'd0;
            entry_bytes_reg         <= 32'd0;
            table_lba_reg           <= 64'd0;
            table_crc_stored_reg    <= 32'd0;
            entry_offset_reg        <= 9'd0;
            guid_candidates_reg     <= 5'h1F;
            signature_candidate_reg <= 1'b1;
            mbr_seen_reg            <= 3'd0;
            gpt_seen_reg            <= 3'd0;
            types_seen_reg          <= 4'd0;
            table_ready_reg         <= 1'b0;
            table_len_reg           <= 17'd0;
            res_valid_reg           <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                last_phase_reg          <= last_phase_next;
                byte_offset_reg         <= byte_offset_next;
                crc_accum_reg           <= crc_accum_next;
                header_length_reg       <= header_length_next;
                header_crc_stored_reg   <= header_crc_stored_next;
                entry_total_reg         <= entry_total_next;
                entry_bytes_reg         <= entry_bytes_next;
                table_lba_reg           <= table_lba_next;
                table_crc_stored_reg    <= table_crc_stored_next;
                entry_offset_reg        <= entry_offset_next;
                guid_candidates_reg     <= guid_candidates_next;
                signature_candidate_reg <= signature_candidate_next;
                mbr_seen_reg            <= mbr_seen_next;
                gpt_seen_reg            <= gpt_seen_next;
                types_seen_reg          <= types_seen_next;
                table_ready_reg         <= table_ready_next;
                table_len_reg           <= table_len_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire && res_load)
        begin
            res_reg <= res_next;
        end
    end

endmodule

@@ rtl/mbr_gpt_boot_sector_checker.sv @@
// ----------------------------------------------------------------------------
// mbr_gpt_boot_sector_checker
// Streaming MBR/GPT bootability checker, one byte per beat.
// ----------------------------------------------------------------------------
// Feed LBA 0 bytes, LBA 1 bytes, then the entry array, then a finish beat.
// One beat is accepted every clock while results are taken. An accepted beat
// is held in the input register, then the state update loads the result
// register. A result that is not taken holds the state update, the input
// register fills and ready drops.
// Array requests come out after the last LBA 1 byte, reports after finish.
// Write sector_bytes only while the block is idle.
module mbr_gpt_boot_sector_checker
(
    input  logic          clk,
    input  logic          rst_n,
    mgbc_item_if.sink     item,
    mgbc_result_if.source result,
    mgbc_cfg_if.sink      cfg
);
    import mgbc_pkg::*;

    logic        stage_valid_reg, stage_valid_next;
    item_t       stage_item_reg;
    logic [12:0] sector_bytes_reg;
    logic        advance;
    result_t     res_data;

    assign cfg.ready  = 1'b1;
    assign item.ready = !stage_valid_reg || advance;

    // Input register
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (item.valid && item.ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            sector_bytes_reg <= MIN_SECTOR;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (cfg.valid)
            begin
                sector_bytes_reg <= cfg.sector_bytes;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            stage_item_reg <= '{action: item.action, data_byte: item.data_byte};
        end
    end

    mgbc_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid_reg),
        .stage_item   (stage_item_reg),
        .sector_bytes (sector_bytes_reg),
        .advance      (advance),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .res_data     (res_data)
    );

    // Drive the result channel
    assign result.result_kind   = res_data.result_kind;
    assign result.array_wanted  = res_data.array_wanted;
    assign result.array_lba     = res_data.array_lba;
    assign result.array_length  = res_data.array_length;
    assign result.mbr_flags     = res_data.mbr_flags;
    assign result.gpt_flags     = res_data.gpt_flags;
    assign result.type_flags    = res_data.type_flags;
    assign result.hybrid        = res_data.hybrid;
    assign result.bios_boot_ok  = res_data.bios_boot_ok;
    assign result.uefi_boot_ok  = res_data.uefi_boot_ok;

endmodule

@@ tb/sv/mgbc_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mgbc_tb_pkg
// Bit-accurate predictor and report store for the boot sector checker bench.
// ----------------------------------------------------------------------------
package mgbc_tb_pkg;
    import mgbc_pkg::*;

    class boot_report_board;
        // Configuration and disk state
        logic [12:0] sec_reg;
        logic [1:0]  phase;
        logic [16:0] offs;
        logic [31:0] crc;
        logic [31:0] hdr_len;
        logic [31:0] hdr_crc;
        logic [31:0] n_entries;
        logic [31:0] entry_sz;
        logic [63:0] tbl_lba;
        logic [31:0] tbl_crc;
        logic [8:0]  ent_off;
        logic [4:0]  guid_cand;
        logic        sig_cand;
        logic [2:0]  mbr_f;
        logic [2:0]  gpt_f;
        logic [3:0]  types_f;
        logic        tbl_ok;
        result_t     pending[$];
        int          errors;

        function new();
            sec_reg = MIN_SECTOR;
            errors  = 0;
            wipe_disk();
        endfunction

        function void wipe_gpt();
            offs = 0; crc = CRC_ONES; hdr_len = 0; hdr_crc = 0; n_entries = 0;
            entry_sz = 0; tbl_lba = 0; tbl_crc = 0; ent_off = 0; guid_cand = 5'h1F;
            sig_cand = 1; gpt_f = 0; types_f = 0; tbl_ok = 0;
        endfunction

        function void wipe_disk();
            wipe_gpt();
            phase = ACT_LBA0;
            mbr_f = 0;
        endfunction

        function logic [31:0] crc8(logic [31:0] c, logic [7:0] b);
            c = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function int unsigned eff_sec();
            if (sec_reg < MIN_SECTOR) return MIN_SECTOR;
            if (sec_reg > MAX_SECTOR_BYTES) return MAX_SECTOR_BYTES;
            return sec_reg;
        endfunction

        function logic [31:0] tbl_len();
            if (!tbl_ok || n_entries > MAX_ENTRIES || entry_sz > MAX_ENTRY_BYTES) return 0;
            return n_entries * entry_sz;
        endfunction

        // Note one accepted beat and queue the result it causes, if any
        function void note_item(logic [1:0] act, logic [7:0] b);
            int unsigned sec;
            int unsigned o;
            logic [31:0] len;
            logic        hl_ok;
            logic        done;
            logic [2:0]  mf;
            logic [2:0]  gf;
            logic [3:0]  tf;
            result_t     r;
            sec = eff_sec();
            r = '0;
            if (act == ACT_FINISH)
            begin
                len  = tbl_len();
                done = (phase == ACT_ARRAY) && len != 0 && offs == len;
                mf   = mbr_f[0] ? mbr_f : 3'd0;
                gf   = {done ? gpt_f[2] : 1'b0, gpt_f[0] & gpt_f[1], gpt_f[0]};
                tf   = done ? types_f : 4'd0;
                r.result_kind   = 1'b1;
                r.mbr_flags     = mf;
                r.gpt_flags     = gf;
                r.type_flags    = tf;
                r.hybrid        = mf[2] && done;
                r.bios_boot_ok  = (mf[0] && mf[1] && !mf[2]) || (gf[1:0] == 2'b11 && tf[1]);
                r.uefi_boot_ok  = gf[1:0] == 2'b11 && tf[0];
                pending.push_back(r);
                wipe_disk();
                return;
            end
            if (act != phase)
            begin
                if (act == ACT_LBA0) wipe_disk();
                else if (act == ACT_LBA1) wipe_gpt();
                else
                begin
                    offs = 0; crc = CRC_ONES; ent_off = 0; guid_cand = 5'h1F;
                    types_f = 0; gpt_f[2] = 0;
                end
                phase = act;
            end
            o = offs;
            if (act == ACT_LBA0)
            begin
                if (o >= sec) return;
                if (o >= 446 && o < 510)
                begin
                    if (((o - 446) % 16) == 0 && b == BOOT_ACTIVE) mbr_f[1] = 1;
                    if (((o - 446) % 16) == 4 && b == TYPE_PROTECTIVE) mbr_f[2] = 1;
                end
                else if (o == 510) sig_cand = (b == SIG_BYTE_LO);
                else if (o == 511 && sig_cand && b == SIG_BYTE_HI) mbr_f[0] = 1;
                offs++;
            end
            else if (act == ACT_LBA1)
            begin
                if (o >= sec) return;
                if (o < 8)
                begin
                    if (b != EFI_SIG[o]) sig_cand = 0;
                    if (o == 7 && sig_cand) gpt_f[0] = 1;
                end
                else if (o >= 12 && o < 16) hdr_len[8*(o-12) +: 8] = b;
                else if (o >= 16 && o < 20) hdr_crc[8*(o-16) +: 8] = b;
                else if (o >= 72 && o < 80) tbl_lba[8*(o-72) +: 8] = b;
                else if (o >= 80 && o < 84) n_entries[8*(o-80) +: 8] = b;
                else if (o >= 84 && o < 88) entry_sz[8*(o-84) +: 8] = b;
                else if (o >= 88 && o < 92) tbl_crc[8*(o-88) +: 8] = b;
                if (o < 16 || o < hdr_len)
                    crc = crc8(crc, (o >= 16 && o < 20) ? 8'd0 : b);
                hl_ok = gpt_f[0] && hdr_len >= MIN_HEADER && hdr_len <= sec;
                if (hl_ok && o == hdr_len - 1 && (crc ^ CRC_ONES) == hdr_crc) gpt_f[1] = 1;
                if (o == sec - 1)
                begin
                    tbl_ok = hl_ok && n_entries != 0 && n_entries <= MAX_ENTRIES &&
                             entry_sz >= MIN_ENTRY && entry_sz <= MAX_ENTRY_BYTES &&
                             tbl_lba >= 2;
                    r.array_wanted = tbl_ok;
                    r.array_lba    = tbl_ok ? tbl_lba : 64'd0;
                    r.array_length = 17'(tbl_len());
                    pending.push_back(r);
                end
                offs++;
            end
            else
            begin
                len = tbl_len();
                if (o >= len) return;
                crc = crc8(crc, b);
                if (ent_off == 0) guid_cand = 5'h1F;
                if (ent_off < 16)
                begin
                    for (int k = 0; k < 5; k++)
                        if (b != PART_TYPE_ID[k][ent_off]) guid_cand[k] = 0;
                    if (ent_off == 15 && !guid_cand[4])
                    begin
                        if (guid_cand[0]) types_f[0] = 1;
                        else if (guid_cand[1]) types_f[1] = 1;
                        else if (guid_cand[2]) types_f[2] = 1;
                        else if (guid_cand[3]) types_f[3] = 1;
                    end
                end
                ent_off = (ent_off + 1 >= entry_sz) ? 9'd0 : ent_off + 9'd1;
                if (o == len - 1 && (crc ^ CRC_ONES) == tbl_crc) gpt_f[2] = 1;
                offs++;
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t: result mismatch expected %h actual %h", $realtime, want, got);
                errors++;
            end
        endfunction
    endclass
endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams synthetic disks through the boot sector checker and compares every
// array request and final report against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb;
    import mgbc_pkg::*;
    import mgbc_tb_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;

    mgbc_item_if   item();
    mgbc_result_if result();
    mgbc_cfg_if    cfg();

    mbr_gpt_boot_sector_checker dut (.clk(clk), .rst_n(rst_n), .item(item),
                                     .result(result), .cfg(cfg));

    boot_report_board board = new();

    int  send_idle_pct = 14;
    int  recv_idle_pct = 62;
    bit  hold_off = 0;
    int  quiet_cycles = 0;
    int  n_items = 0;
    logic [7:0] sector_img [4096];

    always #1 clk = ~clk;

    initial
    begin
        item.valid = 0; item.action = ACT_LBA0; item.data_byte = 0;
        cfg.valid = 0; cfg.sector_bytes = MIN_SECTOR;
        result.ready = 0;
    end

    // Receiver: random stall, or long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n) result.ready <= 0;
        else result.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Score results, watch for a stuck run
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            board.check_result(result_t'{result.result_kind, result.array_wanted,
                result.array_lba, result.array_length, result.mbr_flags,
                result.gpt_flags, result.type_flags, result.hybrid,
                result.bios_boot_ok, result.uefi_boot_ok});
        end
        if ((item.valid && item.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Send one beat, with random leading gaps
    task automatic send_beat(logic [1:0] act, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item.valid <= 0;
            @(posedge clk);
        end
        item.valid <= 1; item.action <= act; item.data_byte <= b;
        // Ready is settled mid-cycle; the beat goes at the next rising edge
        @(negedge clk);
        while (!item.ready) @(negedge clk);
        @(posedge clk);
        board.note_item(act, b);
        n_items++;
    endtask

    task automatic park_input();
        item.valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        park_input();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sector(logic [12:0] v);
        drain();
        cfg.valid <= 1; cfg.sector_bytes <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 0;
        board.sec_reg = v;
        @(posedge clk);
    endtask

    task automatic send_span(logic [1:0] act, int n);
        for (int i = 0; i < n; i++) send_beat(act, sector_img[i]);
    endtask

    // Build and send a whole disk; shape picks how well formed it is
    task automatic send_disk(int shape);
        int unsigned sec;
        int unsigned ents;
        int unsigned esz;
        int unsigned hl;
        int unsigned alen;
        logic [31:0] c;
        logic [7:0]  arr [];
        sec = board.eff_sec();
        // LBA 0
        foreach (sector_img[i]) sector_img[i] = 8'($urandom);
        for (int p = 0; p < 4; p++)
        begin
            if ($urandom_range(3) == 0) sector_img[446 + 16*p] = BOOT_ACTIVE;
            if ($urandom_range(3) == 0) sector_img[450 + 16*p] = TYPE_PROTECTIVE;
        end
        if (shape != 0)
        begin
            sector_img[510] = SIG_BYTE_LO; sector_img[511] = SIG_BYTE_HI;
        end
        send_span(ACT_LBA0, (shape == 3) ? $urandom_range(24) : sec + $urandom_range(3));
        // LBA 1 header
        ents = (shape == 4) ? $urandom_range(200) : $urandom_range(1, 2);
        esz  = (shape == 4) ? $urandom_range(600) : 128 * $urandom_range(1, 2);
        hl   = (shape == 4) ? $urandom_range(sec + 4) : $urandom_range(92, 140);
        foreach (sector_img[i]) sector_img[i] = 8'($urandom);
        for (int i = 0; i < 8; i++) sector_img[i] = EFI_SIG[i];
        if (shape == 5) sector_img[$urandom_range(7)] ^= 8'h01 << $urandom_range(7);
        {sector_img[15], sector_img[14], sector_img[13], sector_img[12]} = hl;
        {sector_img[87], sector_img[86], sector_img[85], sector_img[84]} = esz;
        {sector_img[83], sector_img[82], sector_img[81], sector_img[80]} = ents;
        for (int i = 72; i < 80; i++) sector_img[i] = (i == 72) ? 8'($urandom_range(3)) : 8'd0;
        if ($urandom_range(7) == 0)
            for (int i = 72; i < 80; i++) sector_img[i] = 8'($urandom);
        // Array content with matching type GUIDs
        alen = (ents <= 128 && esz <= 512) ? ents * esz : 0;
        arr = new[alen + 2];
        foreach (arr[i]) arr[i] = 8'($urandom);
        if (esz != 0)
            for (int e = 0; e * esz + 16 <= alen; e++)
            begin
                int g;
                g = $urandom_range(5);
                for (int k = 0; k < 16; k++)
                    if (g < 5) arr[e*esz + k] = PART_TYPE_ID[g][k];
            end
        c = CRC_ONES;
        for (int i = 0; i < alen; i++) c = board.crc8(c, arr[i]);
        c = c ^ CRC_ONES;
        if (shape == 6) c ^= 32'h1;
        {sector_img[91], sector_img[90], sector_img[89], sector_img[88]} = c;
        c = CRC_ONES;
        for (int i = 0; i < hl && i < sec; i++)
            c = board.crc8(c, (i >= 16 && i < 20) ? 8'd0 : sector_img[i]);
        c = c ^ CRC_ONES;
        if (shape == 6) c ^= 32'h100;
        {sector_img[19], sector_img[18], sector_img[17], sector_img[16]} = c;
        send_span(ACT_LBA1, (shape == 3) ? $urandom_range(120) : sec);
        // Array phase, long arrays cut short
        if ($urandom_range(9) != 0)
        begin
            int n;
            n = (shape == 3) ? $urandom_range(8) : alen + $urandom_range(1);
            if (n > 300) n = 300;
            for (int i = 0; i < n; i++) send_beat(ACT_ARRAY, arr[i]);
        end
        send_beat(ACT_FINISH, 8'($urandom));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, each action, special cases
        send_send_directed();

        // Short random disks and beats across idling modes, sector register 0 and 512
        for (int pass = 0; pass < 3; pass++)
        begin
            int goal;
            if (pass == 1) begin send_idle_pct = 62; recv_idle_pct = 14; end
            if (pass == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            write_sector((pass == 1) ? 13'd0 : 13'd512);
            goal = n_items + 80;
            while (n_items < goal)
            begin
                if ($urandom_range(7) == 0)
                    for (int i = 0; i < 20; i++)
                        send_beat(2'($urandom_range(3)), 8'($urandom));
                else
                    send_disk(3);
            end
        end

        // Largest sector, clamped register values
        write_sector(13'd4096);
        send_disk(3);
        write_sector(13'h1FFF);
        send_disk(3);

        // Long receiver hold-off while the sender keeps pushing
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++) send_beat(ACT_FINISH, 8'($urandom));
        join
        write_sector(13'd512);

        drain();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    task automatic send_send_directed();
        send_beat(ACT_FINISH, 8'hFF);
        send_beat(ACT_ARRAY, 8'h00);
        send_beat(ACT_LBA1, 8'hFF);
        send_beat(ACT_FINISH, 8'h00);
        send_beat(ACT_LBA0, 8'h00);
        send_beat(ACT_LBA0, 8'hFF);
        send_beat(ACT_FINISH, 8'hA5);
        // Disk with MBR signature and GPT header, then a pause until every result is back
        send_disk(1);
        drain();
    endtask
endmodule

@@ files.f @@
rtl/mgbc_pkg.sv
rtl/mgbc_if.sv
rtl/mgbc_core.sv
rtl/mbr_gpt_boot_sector_checker.sv
tb/sv/mgbc_tb_pkg.sv
tb/sv/tb.sv
